@@ hdl/kcomb_pkg.sv @@
// ----------------------------------------------------------------------------
// kcomb_pkg
// Shared types, constants and helpers of the k-of-n combination enumerator.
// ----------------------------------------------------------------------------
package kcomb_pkg;

   // Sizing of the value list
   localparam int MAX_SET_SIZE = 16;
   localparam int VALUE_WIDTH  = 32;
   localparam int IDX_W        = $clog2(MAX_SET_SIZE);
   localparam int CNT_W        = $clog2(MAX_SET_SIZE + 1);
   localparam int WIDE_W       = MAX_SET_SIZE + 1;

   // Configuration register layout
   localparam int CSR_W       = 5;
   localparam int CSR_IDX_W   = 4;
   localparam int STATUS_W    = 2;
   localparam int MODE_W      = 2;

   typedef logic [CSR_IDX_W-1:0]    csr_idx_type;
   typedef logic [CSR_W-1:0]        csr_data_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [VALUE_WIDTH-1:0]  value_type;
   typedef logic [MAX_SET_SIZE-1:0] mask_type;

   localparam csr_idx_type REG_SET_SIZE     = csr_idx_type'(0);
   localparam csr_idx_type REG_CHOOSE_COUNT = csr_idx_type'(1);

   // Request modes; the fourth code is ignored
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE   = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_NEXT    = 2'd2
   } mode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ELEMENT   = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_EXHAUSTED = 2'd2
   } status_type;

   // Write request into the value store
   typedef struct packed {
      logic      en;
      idx_type   addr;
      value_type data;
   } store_wr_type;

   // Mask with the low cnt bits set
   function automatic mask_type low_ones(input cnt_type cnt);
      logic [WIDE_W-1:0] wide;
      wide = (WIDE_W'(1) << cnt) - WIDE_W'(1);
      return wide[MAX_SET_SIZE-1:0];
   endfunction

   // Saturate a register value to the list depth
   function automatic cnt_type sat_count(input csr_data_type v);
      if (int'(v) > MAX_SET_SIZE) begin
         return CNT_W'(MAX_SET_SIZE);
      end
      return CNT_W'(v);
   endfunction

endpackage

@@ hdl/kcomb_req_if.sv @@
// ----------------------------------------------------------------------------
// kcomb_req_if
// Request channel: mode, list position and list value.
// ----------------------------------------------------------------------------
interface kcomb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [3:0]  entry_index;
   logic [31:0] entry_value;

   modport source (output valid, output mode, output entry_index, output entry_value,
                   input ready);
   modport sink   (input valid, input mode, input entry_index, input entry_value,
                   output ready);
endinterface

@@ hdl/kcomb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// kcomb_rsp_if
// Response channel: one selected element or a status word per transfer.
// ----------------------------------------------------------------------------
interface kcomb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] element_value;
   logic [3:0]  element_position;
   logic [1:0]  status;
   logic        last_of_run;

   modport source (output valid, output element_value, output element_position,
                   output status, output last_of_run, input ready);
   modport sink   (input valid, input element_value, input element_position,
                   input status, input last_of_run, output ready);
endinterface

@@ hdl/kcomb_csr_if.sv @@
// ----------------------------------------------------------------------------
// kcomb_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kcomb_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] reg_index;
   logic [4:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ hdl/kcomb_store.sv @@
// ----------------------------------------------------------------------------
// kcomb_store
// Generic RAM: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kcomb_store #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry; contents are undefined until written. Register the read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/kcomb_seq.sv @@
// ----------------------------------------------------------------------------
// kcomb_seq
// Request sequencer: walks the selection mask one position per cycle, except
// while a selected entry waits on the response channel, emits the selected
// entries and steps the mask to its lexicographic predecessor.
module kcomb_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  kcomb_pkg::cnt_type       set_n,
   input  kcomb_pkg::cnt_type       choose_k,
   kcomb_req_if.sink                req_chan,
   kcomb_rsp_if.source              rsp_chan,
   output kcomb_pkg::store_wr_type  wr_req,
   output kcomb_pkg::idx_type       rd_addr,
   input  kcomb_pkg::value_type     rd_data
);
   import kcomb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMPTY,
      ST_EXHAUST,
      ST_STEP
   } state_type;

   state_type  state_ff,  state_in;
   cnt_type    pos_ff,    pos_in;
   logic       prev_ff,   prev_in;
   logic       found_ff,  found_in;
   cnt_type    desc_ff,   desc_in;
   cnt_type    ones_ff,   ones_in;
   cnt_type    total_ff,  total_in;
   logic       any_ff,    any_in;
   mask_type   mask_ff,   mask_in;
   logic       more_ff,   more_in;

   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_value_ff, rsp_value_in;
   idx_type    rsp_pos_ff,   rsp_pos_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff,  rsp_last_in;

   logic              req_take;
   logic              slot_free;
   logic              at_end;
   logic              cur_bit;
   idx_type           pos_idx;
   cnt_type           pos_nx;
   mask_type          live_mask;
   logic [WIDE_W-1:0] rest_bits;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // Scan pointer and lookahead for the final selected position
   assign pos_idx   = pos_ff[IDX_W-1:0];
   assign pos_nx    = pos_ff + CNT_W'(1);
   assign at_end    = (pos_ff == set_n);
   assign cur_bit   = mask_ff[pos_idx];
   assign live_mask = mask_ff & low_ones(set_n);
   assign rest_bits = {1'b0, live_mask} >> pos_nx;

   // Address the next scan position so the registered read lines up with it
   assign rd_addr   = pos_in[IDX_W-1:0];

   // Entry writes go straight to the store
   assign wr_req.en   = req_take && (req_chan.mode == MODE_WRITE)
                        && (int'(req_chan.entry_index) < MAX_SET_SIZE);
   assign wr_req.addr = IDX_W'(req_chan.entry_index);
   assign wr_req.data = VALUE_WIDTH'(req_chan.entry_value);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      prev_in       = prev_ff;
      found_in      = found_ff;
      desc_in       = desc_ff;
      ones_in       = ones_ff;
      total_in      = total_ff;
      any_in        = any_ff;
      mask_in       = mask_ff;
      more_in       = more_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (mode_type'(req_chan.mode))
                  MODE_RESTART: begin
                     mask_in = low_ones((choose_k > set_n) ? set_n : choose_k);
                     more_in = 1'b1;
                  end
                  MODE_NEXT: begin
                     pos_in   = '0;
                     prev_in  = 1'b0;
                     found_in = 1'b0;
                     desc_in  = '0;
                     ones_in  = '0;
                     total_in = '0;
                     any_in   = 1'b0;
                     state_in = more_ff ? ST_SCAN : ST_EXHAUST;
                  end
                  default: begin
                     // entry write handled by the store port; unused mode dropped
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (at_end) begin
               state_in = any_ff ? ST_STEP : ST_EMPTY;
            end else if (!cur_bit || slot_free) begin
               // Emit a selected entry
               if (cur_bit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = rd_data;
                  rsp_pos_in    = pos_idx;
                  rsp_status_in = STATUS_ELEMENT;
                  rsp_last_in   = (rest_bits == '0);
               end
               // Track the last one-then-zero pair and the ones after it
               if ((pos_ff != '0) && prev_ff && !cur_bit) begin
                  found_in = 1'b1;
                  desc_in  = pos_ff;
                  ones_in  = '0;
               end else if (cur_bit) begin
                  ones_in = ones_ff + CNT_W'(1);
               end
               total_in = total_ff + CNT_W'(cur_bit);
               prev_in  = cur_bit;
               any_in   = any_ff || cur_bit;
               pos_in   = pos_nx;
            end
         end

         ST_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_pos_in    = '0;
               rsp_status_in = STATUS_EMPTY;
               rsp_last_in   = 1'b1;
               state_in      = ST_STEP;
            end
         end

         ST_EXHAUST: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_pos_in    = '0;
               rsp_status_in = STATUS_EXHAUSTED;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_STEP: begin
            // Predecessor: move the one before the pair up by one and pack the
            // ones after it right behind; otherwise wrap to ones packed low
            if (found_ff) begin
               mask_in = (mask_ff & low_ones(desc_ff - CNT_W'(1)))
                         | (low_ones(desc_ff + ones_ff + CNT_W'(1)) & ~low_ones(desc_ff));
            end else begin
               mask_in = low_ones(total_ff);
            end
            more_in  = found_ff;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         more_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      prev_ff       <= prev_in;
      found_ff      <= found_in;
      desc_ff       <= desc_in;
      ones_ff       <= ones_in;
      total_ff      <= total_in;
      any_ff        <= any_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.element_value    = 32'(rsp_value_ff);
   assign rsp_chan.element_position = 4'(rsp_pos_ff);
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.last_of_run      = rsp_last_ff;

endmodule

@@ hdl/k_of_n_combination_enumerator.sv @@
// ----------------------------------------------------------------------------
// k_of_n_combination_enumerator
// Enumerates the k-element subsets of a loaded value list in lexicographic
// order of the selection mask.
// ----------------------------------------------------------------------------
// Usage: write the list with mode 0 words, set set_size and choose_count, send
// a mode 1 word to restart, then each mode 2 word returns the chosen entries of
// the current combination in position order, the final word flagged with
// last_of_run, and steps to the next combination. An empty combination gives
// one empty-status word; after the last combination each mode 2 word returns
// one exhausted-status word until the next restart. A mode 2 word keeps the
// block busy through its accept, a scan over the mask positions while the
// list is read through a single registered port, a state that closes the scan,
// an empty-status state for an empty combination and a state that steps the
// mask; once exhausted, only through its accept and the exhausted-status word.
// A word that the response channel holds back stalls the block further. No
// request is taken while a mode 2 word is in progress.
module k_of_n_combination_enumerator (
   input  logic        clock,
   input  logic        reset,
   kcomb_req_if.sink   req_chan,
   kcomb_rsp_if.source rsp_chan,
   kcomb_csr_if.sink   csr_chan
);
   import kcomb_pkg::*;

   csr_data_type set_size_ff,     set_size_in;
   csr_data_type choose_count_ff, choose_count_in;
   cnt_type      set_n;
   cnt_type      choose_k;
   store_wr_type wr_req;
   idx_type      rd_addr;
   value_type    rd_data;

   // Register writes are always accepted; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_comb begin
      set_size_in     = set_size_ff;
      choose_count_in = choose_count_ff;
      if (csr_chan.valid) begin
         if (csr_chan.reg_index == REG_SET_SIZE) begin
            set_size_in = CSR_W'(csr_chan.wr_data);
         end
         if (csr_chan.reg_index == REG_CHOOSE_COUNT) begin
            choose_count_in = CSR_W'(csr_chan.wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff     <= CSR_W'(MAX_SET_SIZE);
         choose_count_ff <= '0;
      end else begin
         set_size_ff     <= set_size_in;
         choose_count_ff <= choose_count_in;
      end
   end

   // Saturate the counts to the list depth
   assign set_n    = sat_count(set_size_ff);
   assign choose_k = sat_count(choose_count_ff);

   kcomb_store #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_SET_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_req.en),
      .wr_addr (wr_req.addr),
      .wr_data (wr_req.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kcomb_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .set_n    (set_n),
      .choose_k (choose_k),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .wr_req   (wr_req),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

endmodule

@@ sim/kcomb_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kcomb_checker
// Watches the request, register and response channels of the combination
// enumerator. It keeps its own copy of the value list, the selection mask and
// the registers, predicts the response words of every accepted request and
// compares each accepted response word, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module kcomb_checker
   import kcomb_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   kcomb_req_if  req_chan,
   kcomb_rsp_if  rsp_chan,
   kcomb_csr_if  csr_chan,
   output int    fail_count,
   output int    pending_words,
   output int    element_words,
   output int    empty_words,
   output int    exhausted_words
);

   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      value_type  value;
      idx_type    position;
      status_type status;
      logic       last;
   } combo_word_type;

   // Predicted state of the block
   combo_word_type combo_words[$];
   value_type      list_vals [MAX_SET_SIZE];
   mask_type       sel_mask;
   logic           more_left;
   csr_data_type   size_reg;
   csr_data_type   choose_reg;

   // Number of list positions in use, saturated to the list depth
   function automatic int positions_in_use();
      if (int'(size_reg) > MAX_SET_SIZE) begin
         return MAX_SET_SIZE;
      end
      return int'(size_reg);
   endfunction

   function automatic void queue_word(input value_type value, input int position,
                                      input status_type status, input logic last);
      combo_word_type w;
      w.value     = value;
      w.position  = idx_type'(position);
      w.status    = status;
      w.last      = last;
      combo_words = {combo_words, w};
   endfunction

   // Reverse the bit span [lo, hi) of a mask
   function automatic mask_type mirror_span(input mask_type s, input int lo, input int hi);
      logic t;
      int   a;
      int   b;
      a = lo;
      b = hi - 1;
      while (a < b) begin
         t    = s[a];
         s[a] = s[b];
         s[b] = t;
         a++;
         b--;
      end
      return s;
   endfunction

   // Load k low ones, k clamped to the positions in use
   function automatic void restart_enumeration();
      int k;
      k = int'(choose_reg);
      if (k > positions_in_use()) begin
         k = positions_in_use();
      end
      sel_mask = '0;
      for (int i = 0; i < k; i++) begin
         sel_mask[i] = 1'b1;
      end
      more_left = 1'b1;
   endfunction

   // Predict the words of one next request, then step the mask to its
   // lexicographic predecessor over positions 0..n-1
   function automatic void predict_combination();
      int       n;
      int       top_pos;
      int       pivot;
      int       j;
      mask_type seq;
      n = positions_in_use();
      if (!more_left) begin
         queue_word('0, 0, STATUS_EXHAUSTED, 1'b1);
         return;
      end
      top_pos = -1;
      for (int i = 0; i < n; i++) begin
         if (sel_mask[i]) begin
            top_pos = i;
         end
      end
      if (top_pos < 0) begin
         queue_word('0, 0, STATUS_EMPTY, 1'b1);
      end else begin
         for (int i = 0; i < n; i++) begin
            if (sel_mask[i]) begin
               queue_word(list_vals[i], i, STATUS_ELEMENT, i == top_pos);
            end
         end
      end
      // Drop mask bits beyond the positions in use
      seq = '0;
      for (int i = 0; i < n; i++) begin
         seq[i] = sel_mask[i];
      end
      // Find the rightmost one followed by a zero
      pivot = 0;
      for (int i = 1; i < n; i++) begin
         if (seq[i-1] && !seq[i]) begin
            pivot = i;
         end
      end
      if (pivot == 0) begin
         // No predecessor: wrap to the largest arrangement
         seq       = mirror_span(seq, 0, n);
         more_left = 1'b0;
      end else begin
         j = n - 1;
         while (seq[j]) begin
            j--;
         end
         seq[pivot-1] = 1'b0;
         seq[j]       = 1'b1;
         seq          = mirror_span(seq, pivot, n);
      end
      sel_mask = seq;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: response %s mismatch: got %0h, expected %0h", $realtime, what, got,
                  want);
      end
   endtask

   // Track register writes and requests, check response words
   always @(posedge clock) begin
      combo_word_type want;
      if (reset) begin
         combo_words.delete();
         for (int i = 0; i < MAX_SET_SIZE; i++) begin
            list_vals[i] = '0;
         end
         sel_mask   = '0;
         more_left  = 1'b1;
         size_reg   = csr_data_type'(16);
         choose_reg = '0;
      end else begin
         if (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1) begin
            if (csr_chan.reg_index == REG_SET_SIZE) begin
               size_reg = csr_chan.wr_data;
            end else if (csr_chan.reg_index == REG_CHOOSE_COUNT) begin
               choose_reg = csr_chan.wr_data;
            end
         end

         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (combo_words.size() == 0) begin
               report_mismatch("word with nothing expected, status",
                               32'(rsp_chan.status), 32'(0));
            end else begin
               want = combo_words.pop_front();
               if (rsp_chan.element_value !== want.value) begin
                  report_mismatch("element_value", rsp_chan.element_value, want.value);
               end
               if (rsp_chan.element_position !== want.position) begin
                  report_mismatch("element_position", 32'(rsp_chan.element_position),
                                  32'(want.position));
               end
               if (rsp_chan.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
               end
               if (rsp_chan.last_of_run !== want.last) begin
                  report_mismatch("last_of_run", 32'(rsp_chan.last_of_run), 32'(want.last));
               end
               case (want.status)
                  STATUS_ELEMENT: element_words++;
                  STATUS_EMPTY:   empty_words++;
                  default:        exhausted_words++;
               endcase
            end
         end

         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            case (req_chan.mode)
               MODE_WRITE:   list_vals[req_chan.entry_index] = req_chan.entry_value;
               MODE_RESTART: restart_enumeration();
               MODE_NEXT:    predict_combination();
               default:      ;
            endcase
         end
      end
      pending_words <= combo_words.size();
   end

endmodule

@@ sim/k_of_n_combination_enumerator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_of_n_combination_enumerator_tb
// Drives the combination enumerator with a directed opening (list load,
// extreme sizes, clamping, empty and exhausted enumerations, stale masks)
// and then with random phases of restart-and-step sequences under changing
// register settings, while the response side stalls. The checker beside the
// block predicts and compares every response word.
// ----------------------------------------------------------------------------
module k_of_n_combination_enumerator_tb;
   import kcomb_pkg::*;

   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   localparam int TARGET_ITEMS   = 440;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 2 * (MAX_SET_SIZE + 3);
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_style_type;

   logic clock;
   logic reset;

   kcomb_req_if req_chan ();
   kcomb_rsp_if rsp_chan ();
   kcomb_csr_if csr_chan ();

   int fail_count;
   int pending_words;
   int element_words;
   int empty_words;
   int exhausted_words;

   int items_sent;
   int settings_applied;
   int burst_left;
   int hold_requests;
   int idle_cycles;
   bit quiet_sender;

   k_of_n_combination_enumerator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   kcomb_checker combo_check (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_chan        (csr_chan),
      .fail_count      (fail_count),
      .pending_words   (pending_words),
      .element_words   (element_words),
      .empty_words     (empty_words),
      .exhausted_words (exhausted_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: switch between open, random and patterned stalls, and hold
   // off for a long stretch whenever the stimulus asks for it
   initial begin
      sink_style_type style;
      int             style_left;
      int             hold_left;
      int             hold_seen;
      logic [31:0]    stall_pattern;
      style_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (style_left == 0) begin
            style         = sink_style_type'($urandom_range(0, 2));
            style_left    = $urandom_range(20, 200);
            stall_pattern = $urandom() | 32'h1;
         end
         style_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (style)
               SINK_OPEN:   rsp_chan.ready <= 1'b1;
               SINK_RANDOM: rsp_chan.ready <= ($urandom_range(0, 2) != 0);
               default: begin
                  rsp_chan.ready <= stall_pattern[0];
                  stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
               end
            endcase
         end
      end
   end

   // Watchdog: end the run after a long stretch without any handshake
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                  idle_cycles, pending_words);
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one request word in bursts with random gaps, hold until accepted
   task automatic send_word(input logic [MODE_W-1:0] mode, input idx_type idx,
                            input value_type value);
      int gap;
      if (burst_left == 0) begin
         gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.entry_index <= idx;
      req_chan.entry_value <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (mode != MODE_IGNORED) begin
         items_sent++;
      end
   endtask

   task automatic send_next();
      send_word(MODE_NEXT, idx_type'($urandom()), $urandom());
   endtask

   task automatic send_restart();
      send_word(MODE_RESTART, idx_type'($urandom()), $urandom());
   endtask

   // Stop offering words until every predicted word has come, then let the
   // block settle
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input csr_data_type data);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data   <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
   endtask

   // Write both registers while the block is idle
   task automatic apply_setting(input int set_size, input int choose_count);
      drain_responses();
      write_register(REG_SET_SIZE, csr_data_type'(set_size));
      write_register(REG_CHOOSE_COUNT, csr_data_type'(choose_count));
      csr_chan.valid <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      value_type seed_vals [6];
      int        ext_n     [6];
      int        ext_k     [6];
      int        phase;
      int        phase_len;
      int        taken;
      int        pick;
      int        run_len;
      int        n;
      int        k;
      value_type value;

      seed_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                    32'h5555_5555, 32'hAAAA_AAAA};
      ext_n = '{0, 16, 16, 1, 31, 7};
      ext_k = '{0, 16, 8, 1, 31, 31};

      items_sent       = 0;
      settings_applied = 0;
      burst_left       = 0;
      quiet_sender     = 1'b0;
      hold_requests    <= 0;
      reset            <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.mode        <= MODE_WRITE;
      req_chan.entry_index <= '0;
      req_chan.entry_value <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.reg_index   <= REG_SET_SIZE;
      csr_chan.wr_data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty combination straight out of reset, then load every list entry
      send_next();
      for (int i = 0; i < MAX_SET_SIZE; i++) begin
         value = (i < 6) ? seed_vals[i] : $urandom();
         send_word(MODE_WRITE, idx_type'(i), value);
      end

      // Full-size single combination, then exhausted, then an ignored word
      apply_setting(16, 16);
      send_restart();
      send_next();
      send_next();
      send_word(MODE_IGNORED, '1, '1);

      // Oversized set and count saturate and clamp
      apply_setting(31, 31);
      send_restart();
      send_next();

      // Shrink the set under a live mask: upper mask bits are ignored
      apply_setting(16, 3);
      send_restart();
      apply_setting(2, 3);
      send_next();

      // Zero count: one empty combination, then exhausted
      apply_setting(5, 0);
      send_restart();
      send_next();
      send_next();

      // Random phases under changing settings
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         if (phase < 6) begin
            n = ext_n[phase];
            k = ext_k[phase];
         end else begin
            pick = $urandom_range(0, 9);
            n = (pick < 7) ? $urandom_range(0, 6) :
                (pick < 9) ? $urandom_range(7, 16) : $urandom_range(17, 31);
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
                $urandom_range(0, ((n > 16) ? 16 : n) + 1);
         end
         apply_setting(n, k);
         quiet_sender = ($urandom_range(0, 3) == 0);
         phase_len    = $urandom_range(10, 40);
         taken        = 0;

         // Hold the response side off while requests keep coming
         if (phase == 2) begin
            hold_requests <= hold_requests + 1;
            send_restart();
            repeat (6) send_next();
            taken = 7;
         end

         while (taken < phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               value = $urandom();
               if ($urandom_range(0, 3) == 0) begin
                  value = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
               end
               send_word(MODE_WRITE, idx_type'($urandom_range(0, 15)), value);
               taken++;
            end else if (pick < 13) begin
               send_word(MODE_IGNORED, idx_type'($urandom()), $urandom());
            end else if (pick < 23) begin
               send_next();
               taken++;
            end else begin
               run_len = $urandom_range(1, 12);
               send_restart();
               repeat (run_len) send_next();
               taken += run_len + 1;
            end
         end
         phase++;
      end

      drain_responses();
      $display("Covered %0d request words over %0d register settings, with a %0d-cycle hold-off",
               items_sent, settings_applied, LONG_HOLD);
      $display("Checked %0d element, %0d empty and %0d exhausted response words",
               element_words, empty_words, exhausted_words);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
